// File: rtl/scrgb_pkg.sv
// Shared constants and types for the scalar-to-RGB colormap.
// Fixed-point format, field widths, map mode codes and the color word type.
// No dependencies.
`default_nettype none

package scrgb_pkg;

    // Fraction bits of the scalar; ONE (1.0) is 2**FRACTION_BITS.
    localparam int FRACTION_BITS = 16;

    localparam int IN_W  = 18;                  // scalar_value field
    localparam int CH_W  = 8;                   // one color channel
    localparam int X_W   = FRACTION_BITS + 1;   // clamped scalar, 0..ONE
    localparam int CMP_W = (IN_W > X_W) ? IN_W : X_W;
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_BLUE_HOT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DIVERGING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RAINBOW   = 2'd2;

    localparam logic [2:0] SECT_RED_YEL = 3'd0;
    localparam logic [2:0] SECT_YEL_GRN = 3'd1;
    localparam logic [2:0] SECT_GRN_CYN = 3'd2;
    localparam logic [2:0] SECT_CYN_BLU = 3'd3;
    localparam logic [2:0] SECT_BLU_MAG = 3'd4;
    localparam logic [2:0] SECT_MAG_RED = 3'd5;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

endpackage

`default_nettype wire

// File: rtl/scrgb_map.sv
// Combinational colormap: clamps the scalar and evaluates the selected map.
// Depends on scrgb_pkg.
`default_nettype none

module scrgb_map
    import scrgb_pkg::*;
(
    input  wire logic signed [IN_W-1:0]   i_scalar,
    input  wire logic        [MODE_W-1:0] i_mode,
    output t_rgb                          o_rgb
);

    localparam int P_W = X_W + 9;   // room for 510 * ONE
    localparam int H_W = X_W + 3;   // room for 6 * ONE

    localparam logic [CMP_W-1:0] ONE_C  = CMP_W'(1) << FRACTION_BITS;
    localparam logic [X_W-1:0]   ONE_X  = X_W'(1) << FRACTION_BITS;
    localparam logic [X_W-1:0]   HALF_X = X_W'(1) << (FRACTION_BITS - 1);
    localparam logic [P_W-1:0]   RND    = P_W'((64'd1 << FRACTION_BITS) - 64'd1);

    logic [CMP_W-1:0]        raw_ext;
    logic [X_W-1:0]          x;
    logic [X_W-1:0]          d;
    logic [P_W-1:0]          p255;
    logic [P_W-1:0]          p127;
    logic [P_W-1:0]          p510;
    logic [P_W-1:0]          p254;
    logic [P_W-1:0]          c254;
    logic [P_W-1:0]          c510;
    logic [H_W-1:0]          h;
    logic [2:0]              sect;
    logic [FRACTION_BITS-1:0] f;
    logic [P_W-1:0]          pup;
    logic [P_W-1:0]          pdn;
    logic [CH_W-1:0]         up;
    logic [CH_W-1:0]         dn;
    t_rgb                    bh_rgb;
    t_rgb                    dv_rgb;
    t_rgb                    hv_rgb;

    // clamp to 0..ONE
    assign raw_ext = CMP_W'($unsigned(i_scalar));

    always_comb begin
        if (i_scalar[IN_W-1]) begin
            x = '0;
        end else if (raw_ext > ONE_C) begin
            x = ONE_X;
        end else begin
            x = X_W'(raw_ext);
        end
    end

    // blue-hot
    assign p255 = P_W'(x) * P_W'(255);
    assign p127 = P_W'(x) * P_W'(127);
    always_comb begin
        bh_rgb.red   = CH_W'(p255 >> FRACTION_BITS);
        bh_rgb.green = bh_rgb.red;
        bh_rgb.blue  = CH_W'(128) + CH_W'(p127 >> FRACTION_BITS);
    end

    // diverging; the upper half rounds its decrement up
    assign d    = x - HALF_X;
    assign p510 = P_W'(x) * P_W'(510);
    assign p254 = P_W'(x) * P_W'(254);
    assign c254 = P_W'(d) * P_W'(254) + RND;
    assign c510 = P_W'(d) * P_W'(510) + RND;
    always_comb begin
        if (x <= HALF_X) begin
            dv_rgb.red   = CH_W'(p510 >> FRACTION_BITS);
            dv_rgb.green = dv_rgb.red;
            dv_rgb.blue  = CH_W'(128) + CH_W'(p254 >> FRACTION_BITS);
        end else begin
            dv_rgb.red   = CH_W'(255) - CH_W'(c254 >> FRACTION_BITS);
            dv_rgb.green = CH_W'(255) - CH_W'(c510 >> FRACTION_BITS);
            dv_rgb.blue  = dv_rgb.green;
        end
    end

    // HSV rainbow, six sectors; a full turn falls to the default (red)
    assign h    = H_W'(x) * H_W'(6);
    assign sect = h[FRACTION_BITS +: 3];
    assign f    = h[FRACTION_BITS-1:0];
    assign pup  = P_W'(f) * P_W'(255);
    assign pdn  = P_W'(ONE_X - X_W'(f)) * P_W'(255);
    assign up   = CH_W'(pup >> FRACTION_BITS);
    assign dn   = CH_W'(pdn >> FRACTION_BITS);

    always_comb begin
        case (sect)
            SECT_YEL_GRN: hv_rgb = '{red: dn,        green: CH_W'(255), blue: '0};
            SECT_GRN_CYN: hv_rgb = '{red: '0,        green: CH_W'(255), blue: up};
            SECT_CYN_BLU: hv_rgb = '{red: '0,        green: dn,         blue: CH_W'(255)};
            SECT_BLU_MAG: hv_rgb = '{red: up,        green: '0,         blue: CH_W'(255)};
            SECT_MAG_RED: hv_rgb = '{red: CH_W'(255), green: '0,        blue: dn};
            default:      hv_rgb = '{red: CH_W'(255), green: up,        blue: '0};
        endcase
    end

    always_comb begin
        case (i_mode)
            MODE_BLUE_HOT:  o_rgb = bh_rgb;
            MODE_DIVERGING: o_rgb = dv_rgb;
            MODE_RAINBOW:   o_rgb = hv_rgb;
            default:        o_rgb = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/scalar_to_rgb_colormap.sv
// Top level of the scalar-to-RGB colormap: input register, map logic, result register.
// Depends on scrgb_pkg and scrgb_map.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | i_valid, o_stall, i_scalar_value        | in
//   result  | o_valid, i_stall, o_red/o_green/o_blue  | out
//   config  | i_cfg_we, i_cfg_wdata (map_mode)        | in
//
// Two register stages: a word is accepted into the input register, mapped
// combinationally, and moves into the result register once that register is free;
// one word per cycle while the result side does not stall.
// Synchronous active-low reset clears both valid flags and sets map_mode to blue-hot.
// A stall on the result side holds the result register and backs up into the
// input register; o_stall rises only when both stages are full.
`default_nettype none

module scalar_to_rgb_colormap
    import scrgb_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   i_cfg_we,
    input  wire logic [MODE_W-1:0]      i_cfg_wdata,

    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic signed [IN_W-1:0] i_scalar_value,

    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [CH_W-1:0]             o_red,
    output logic [CH_W-1:0]             o_green,
    output logic [CH_W-1:0]             o_blue
);

    logic [MODE_W-1:0]      r_map_mode;
    logic                   r_in_valid;
    logic signed [IN_W-1:0] r_in_scalar;
    logic                   r_out_valid;
    t_rgb                   r_out_rgb;

    logic                   n_in_valid;
    logic                   n_out_valid;
    logic                   out_free;
    logic                   in_move;
    logic                   in_take;
    t_rgb                   map_rgb;

    assign out_free = !r_out_valid || !i_stall;
    assign in_move  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    assign n_in_valid  = in_take || (r_in_valid && !in_move);
    assign n_out_valid = in_move || (r_out_valid && i_stall);

    scrgb_map u_map (
        .i_scalar (r_in_scalar),
        .i_mode   (r_map_mode),
        .o_rgb    (map_rgb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_mode  <= MODE_BLUE_HOT;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_map_mode <= i_cfg_wdata;
            end
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_scalar <= i_scalar_value;
        end
        if (in_move) begin
            r_out_rgb <= map_rgb;
        end
    end

    assign o_valid = r_out_valid;
    assign o_red   = r_out_rgb.red;
    assign o_green = r_out_rgb.green;
    assign o_blue  = r_out_rgb.blue;

endmodule

`default_nettype wire

// File: sim/tb_scalar_to_rgb_colormap.sv
// Testbench for scalar_to_rgb_colormap: directed and random scalars in every map mode,
// checked word by word against a predictor kept in a small scoreboard class.
// Depends on scrgb_pkg and the colormap RTL.

module tb_scalar_to_rgb_colormap
    import scrgb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // map_mode 3 has no name in the package; it gives black
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int ONE_VAL     = 1 << FRACTION_BITS;
    localparam int PHASES      = 13;
    localparam int PHASE_WORDS = 100;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 2000;

    class rgb_scoreboard;
        t_rgb            pending[$];
        logic [MODE_W-1:0] mode;
        int              errors;

        function new();
            mode   = MODE_BLUE_HOT;
            errors = 0;
        endfunction

        // Exact integer form of the three maps on the clamped scalar.
        function t_rgb colormap(logic signed [IN_W-1:0] s, logic [MODE_W-1:0] m);
            longint          sval;
            longint unsigned one, half, x, d, h, sec, f, up, dn, r, g, b;
            t_rgb            c;
            one  = 64'd1 << FRACTION_BITS;
            half = one >> 1;
            sval = s;
            if (sval < 0)
                x = 0;
            else if (sval > longint'(one))
                x = one;
            else
                x = sval;
            r = 0;
            g = 0;
            b = 0;
            case (m)
                MODE_BLUE_HOT: begin
                    r = (255 * x) / one;
                    g = r;
                    b = 128 + (127 * x) / one;
                end
                MODE_DIVERGING: begin
                    if (x <= half) begin
                        r = (510 * x) / one;
                        g = r;
                        b = 128 + (254 * x) / one;
                    end else begin
                        d = x - half;
                        r = 255 - (254 * d + one - 1) / one;
                        g = 255 - (510 * d + one - 1) / one;
                        b = g;
                    end
                end
                MODE_RAINBOW: begin
                    h   = 6 * x;
                    sec = h / one;
                    f   = h % one;
                    up  = (255 * f) / one;
                    dn  = (255 * (one - f)) / one;
                    // a full turn (sector 6) wraps to red
                    case (sec)
                        SECT_YEL_GRN: begin r = dn;  g = 255; b = 0;   end
                        SECT_GRN_CYN: begin r = 0;   g = 255; b = up;  end
                        SECT_CYN_BLU: begin r = 0;   g = dn;  b = 255; end
                        SECT_BLU_MAG: begin r = up;  g = 0;   b = 255; end
                        SECT_MAG_RED: begin r = 255; g = 0;   b = dn;  end
                        default:      begin r = 255; g = up;  b = 0;   end
                    endcase
                end
                default: ;
            endcase
            c.red   = r[CH_W-1:0];
            c.green = g[CH_W-1:0];
            c.blue  = b[CH_W-1:0];
            return c;
        endfunction

        function void note_input(logic signed [IN_W-1:0] s);
            pending.push_back(colormap(s, mode));
        endfunction

        function void check_result(t_rgb got);
            t_rgb exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected color word %0d/%0d/%0d", $time,
                         got.red, got.green, got.blue);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.red !== exp.red) begin
                $display("%0t: red expected %0d got %0d", $time, exp.red, got.red);
                errors++;
            end
            if (got.green !== exp.green) begin
                $display("%0t: green expected %0d got %0d", $time, exp.green, got.green);
                errors++;
            end
            if (got.blue !== exp.blue) begin
                $display("%0t: blue expected %0d got %0d", $time, exp.blue, got.blue);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [MODE_W-1:0]      i_cfg_wdata;
    logic                   i_valid;
    logic                   o_stall;
    logic signed [IN_W-1:0] i_scalar_value;
    logic                   o_valid;
    logic                   i_stall;
    logic [CH_W-1:0]        o_red;
    logic [CH_W-1:0]        o_green;
    logic [CH_W-1:0]        o_blue;

    rgb_scoreboard sb = new();

    int gap_max;
    int stall_max;
    bit hold_req;
    int idle_cycles = 0;

    scalar_to_rgb_colormap u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_scalar_value (i_scalar_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_word(input logic signed [IN_W-1:0] v);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_scalar_value <= v;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        sb.note_input(v);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] m);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.mode = m;
    endtask

    // Mostly in-range values, some near sector and midpoint edges, some raw 18-bit.
    function automatic logic signed [IN_W-1:0] draw_scalar();
        int k;
        case ($urandom_range(0, 9))
            0, 1: return IN_W'($urandom);
            2: begin
                k = $urandom_range(0, 6);
                return IN_W'(k * ONE_VAL / 6 + int'($urandom_range(0, 6)) - 3);
            end
            3: return IN_W'(ONE_VAL / 2 + int'($urandom_range(0, 6)) - 3);
            default: return IN_W'($urandom_range(0, ONE_VAL));
        endcase
    endfunction

    // Receiver: random stall per word, with an occasional long hold.
    initial begin
        int n;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            n = $urandom_range(0, stall_max);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result('{red: o_red, green: o_green, blue: o_blue});
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ((i_valid && !o_stall) || (o_valid && !i_stall)))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int dir_hot[6]   = '{-131072, 0, 1, 32768, 65536, 131071};
        int dir_div[6]   = '{32767, 32768, 32769, 65535, 65536, -1};
        int dir_hue[8]   = '{0, 10923, 21846, 32768, 43691, 54614, 65535, 65536};
        int dir_black[3] = '{65536, 131071, -131072};
        logic [MODE_W-1:0] phase_mode[PHASES] = '{
            MODE_RAINBOW, MODE_DIVERGING, MODE_BLUE_HOT, MODE_UNUSED, MODE_RAINBOW,
            MODE_DIVERGING, MODE_BLUE_HOT, MODE_RAINBOW, MODE_UNUSED, MODE_DIVERGING,
            MODE_RAINBOW, MODE_BLUE_HOT, MODE_DIVERGING};

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_valid        = 1'b0;
        i_scalar_value = '0;
        gap_max        = 3;
        stall_max      = 3;
        hold_req       = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_mode(MODE_BLUE_HOT);
        foreach (dir_hot[i]) send_word(IN_W'(dir_hot[i]));
        write_mode(MODE_DIVERGING);
        foreach (dir_div[i]) send_word(IN_W'(dir_div[i]));
        write_mode(MODE_RAINBOW);
        foreach (dir_hue[i]) send_word(IN_W'(dir_hue[i]));
        write_mode(MODE_UNUSED);
        foreach (dir_black[i]) send_word(IN_W'(dir_black[i]));

        for (int p = 0; p < PHASES; p++) begin
            write_mode(phase_mode[p]);
            gap_max   = (p % 3 == 0) ? 0 : 19;
            stall_max = (p % 4 == 1) ? 0 : 19;
            // one phase: receiver holds off while words keep coming, filling the pipe
            if (p == 4) begin
                gap_max  = 0;
                hold_req = 1'b1;
            end
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (k == PHASE_WORDS / 2 && p % 2 == 0)
                    wait_drained();
                send_word(draw_scalar());
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/scrgb_pkg.sv
rtl/scrgb_map.sv
rtl/scalar_to_rgb_colormap.sv
sim/tb_scalar_to_rgb_colormap.sv
